// ----- hw/rtl/vfa_pkg.sv -----
// Shared types, constants and helpers for the three-component vector ALU.
// No dependencies; the ALU, square root, divider and testbench import this package.
`default_nettype none

package vfa_pkg;

  // Default number of fraction bits of the fixed-point words
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Field and datapath widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned TOL_W  = 31;
  localparam int unsigned DEN_W  = 33;
  localparam int unsigned RAD_W  = 64;

  // Square root: 32 result bits, SQRT_STEPS of them per stage
  localparam int unsigned SQRT_STEPS  = 2;
  localparam int unsigned SQRT_STAGES = 32 / SQRT_STEPS;

  // Divider: quotient bits per stage
  localparam int unsigned DIV_STEPS = 2;

  // Tolerance after reset, about 0.0001 in Q16.16
  localparam logic [TOL_W-1:0] TOL_RESET = 31'd7;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_DIV   = 3'd3,
    OP_EQ    = 3'd4,
    OP_NORM  = 3'd5,
    OP_LEN   = 3'd6
  } op_e;

  // Saturated 32-bit word and its clamp flag
  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] val;
  } pack_t;

  // Side data carried through the square root pipeline
  typedef struct packed {
    op_e                    op;
    logic [2:0][DATA_W-1:0] r;
    logic                   match;
    logic                   sat;
    logic [2:0][DATA_W-1:0] ma;
    logic [2:0]             na;
    logic [DATA_W-1:0]      ms;
    logic                   ns;
    logic                   szero;
  } sb_sqrt_t;

  // Side data carried through the divider pipeline
  typedef struct packed {
    op_e                    op;
    logic [2:0][DATA_W-1:0] r;
    logic                   match;
    logic                   sat;
    logic                   fault;
    logic [2:0]             neg;
  } sb_div_t;

  // Turn a sign and a magnitude into a saturated two's complement word
  function automatic pack_t sat_pack(input logic neg, input logic [63:0] mag);
    pack_t p;
    p.sat = 1'b0;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        p.sat = 1'b1;
        p.val = 32'h8000_0000;
      end else begin
        p.val = 32'(64'd0 - mag);
      end
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) begin
        p.sat = 1'b1;
        p.val = 32'h7FFF_FFFF;
      end else begin
        p.val = mag[31:0];
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/vfa_cfg_if.sv -----
// Configuration write channel of the vector ALU: valid, ready and tolerance.
// No dependencies.
`default_nettype none

interface vfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] equal_tolerance;

  modport source (output valid, output equal_tolerance, input ready);
  modport sink   (input valid, input equal_tolerance, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/vfa_req_if.sv -----
// Request channel of the vector ALU: opcode, two vectors and a scalar.
// No dependencies.
`default_nettype none

interface vfa_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] scalar;

  modport source (output valid, output req_type, output a_x, output a_y, output a_z,
                  output b_x, output b_y, output b_z, output scalar, input ready);
  modport sink   (input valid, input req_type, input a_x, input a_y, input a_z,
                  input b_x, input b_y, input b_z, input scalar, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/vfa_res_if.sv -----
// Result channel of the vector ALU: three components and three flags.
// No dependencies.
`default_nettype none

interface vfa_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic signed [31:0] res_z;
  logic               match_flag;
  logic               fault;
  logic               saturated;

  modport source (output valid, output res_x, output res_y, output res_z,
                  output match_flag, output fault, output saturated, input ready);
  modport sink   (input valid, input res_x, input res_y, input res_z,
                  input match_flag, input fault, input saturated, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/vfa_sqrt.sv -----
// Pipelined integer square root of a 64-bit radicand, floor root and remainder.
// Depends on vfa_pkg; SQRT_STEPS result bits are resolved in each stage.
`default_nettype none

module vfa_sqrt import vfa_pkg::*; #(
  parameter int unsigned SB_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [RAD_W-1:0]    rad_i,
  input  logic [SB_W-1:0]     sb_i,
  output logic                valid_o,
  output logic [DATA_W-1:0]   root_o,
  output logic [DATA_W:0]     rem_o,
  output logic [SB_W-1:0]     sb_o
);

  localparam int unsigned LAST = SQRT_STAGES - 1;

  logic             vld_q [SQRT_STAGES];
  logic [RAD_W-1:0] v_q   [SQRT_STAGES];
  logic [RAD_W-1:0] r_q   [SQRT_STAGES];
  logic [SB_W-1:0]  sb_q  [SQRT_STAGES];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    logic             vld_in;
    logic [RAD_W-1:0] v_in, r_in, v_d, r_d;
    logic [SB_W-1:0]  sb_in;

    if (j == 0) begin : g_first
      assign vld_in = valid_i;
      assign v_in   = rad_i;
      assign r_in   = '0;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign vld_in = vld_q[j-1];
      assign v_in   = v_q[j-1];
      assign r_in   = r_q[j-1];
      assign sb_in  = sb_q[j-1];
    end

    // Resolve the next result bits: subtract when the trial fits
    always_comb begin
      logic [RAD_W-1:0] bitv;
      v_d = v_in;
      r_d = r_in;
      for (int t = 0; t < SQRT_STEPS; t++) begin
        bitv = 64'd1 << (62 - 2 * (SQRT_STEPS * j + t));
        if (v_d >= r_d + bitv) begin
          v_d = v_d - (r_d + bitv);
          r_d = (r_d >> 1) + bitv;
        end else begin
          r_d = r_d >> 1;
        end
      end
    end

    // Advance valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    // Advance payload
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[j]  <= v_d;
        r_q[j]  <= r_d;
        sb_q[j] <= sb_in;
      end
    end
  end

  assign valid_o = vld_q[LAST];
  assign root_o  = r_q[LAST][DATA_W-1:0];
  assign rem_o   = v_q[LAST][DATA_W:0];
  assign sb_o    = sb_q[LAST];

  // The remainder of a floor root never exceeds twice the root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LAST] |-> (v_q[LAST] <= (r_q[LAST] << 1)))
    else $error("square root remainder out of range");

endmodule

`default_nettype wire

// ----- hw/rtl/vfa_div.sv -----
// Pipelined restoring divider, three lanes sharing one divisor.
// Depends on vfa_pkg; DIV_STEPS quotient bits are resolved in each stage.
`default_nettype none

module vfa_div import vfa_pkg::*; #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned SB_W  = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [2:0][NUM_W-1:0]       num_i,
  input  logic [DEN_W-1:0]            den_i,
  input  logic [SB_W-1:0]             sb_i,
  output logic                        valid_o,
  output logic [2:0][NUM_W-1:0]       quo_o,
  output logic [2:0][DEN_W-1:0]       rem_o,
  output logic [DEN_W-1:0]            den_o,
  output logic [SB_W-1:0]             sb_o
);

  localparam int unsigned DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned PAD_W      = DIV_STAGES * DIV_STEPS;
  localparam int unsigned LAST       = DIV_STAGES - 1;

  logic             vld_q [DIV_STAGES];
  logic [DEN_W-1:0] den_q [DIV_STAGES];
  logic [SB_W-1:0]  sb_q  [DIV_STAGES];
  logic [PAD_W-1:0] n_q   [DIV_STAGES][3];
  logic [PAD_W-1:0] q_q   [DIV_STAGES][3];
  logic [DEN_W-1:0] r_q   [DIV_STAGES][3];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic             vld_in;
    logic [DEN_W-1:0] den_in;
    logic [SB_W-1:0]  sb_in;

    if (j == 0) begin : g_first
      assign vld_in = valid_i;
      assign den_in = den_i;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign vld_in = vld_q[j-1];
      assign den_in = den_q[j-1];
      assign sb_in  = sb_q[j-1];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [PAD_W-1:0] n_in, q_in, n_d, q_d;
      logic [DEN_W-1:0] r_in, r_d;

      if (j == 0) begin : g_first
        assign n_in = PAD_W'(num_i[l]);
        assign q_in = '0;
        assign r_in = '0;
      end else begin : g_next
        assign n_in = n_q[j-1][l];
        assign q_in = q_q[j-1][l];
        assign r_in = r_q[j-1][l];
      end

      // Shift in numerator bits, subtract the divisor where it fits
      always_comb begin
        logic [DEN_W:0] rw;
        n_d = n_in;
        q_d = q_in;
        r_d = r_in;
        for (int t = 0; t < DIV_STEPS; t++) begin
          rw  = {r_d, n_d[PAD_W-1]};
          n_d = n_d << 1;
          if (rw >= {1'b0, den_in}) begin
            r_d = DEN_W'(rw - {1'b0, den_in});
            q_d = {q_d[PAD_W-2:0], 1'b1};
          end else begin
            r_d = rw[DEN_W-1:0];
            q_d = {q_d[PAD_W-2:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          n_q[j][l] <= n_d;
          q_q[j][l] <= q_d;
          r_q[j][l] <= r_d;
        end
      end
    end

    // Advance valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    // Advance shared payload
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j] <= den_in;
        sb_q[j]  <= sb_in;
      end
    end
  end

  assign valid_o = vld_q[LAST];
  assign den_o   = den_q[LAST];
  assign sb_o    = sb_q[LAST];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quo_o[l] = q_q[LAST][l][NUM_W-1:0];
    assign rem_o[l] = r_q[LAST][l];
  end

  // A finished division leaves every remainder below a nonzero divisor
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAST] && den_q[LAST] != '0) |->
      (r_q[LAST][0] < den_q[LAST] && r_q[LAST][1] < den_q[LAST] &&
       r_q[LAST][2] < den_q[LAST]))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// ----- hw/rtl/vec3_fixed_alu.sv -----
// Three-component fixed-point vector ALU: add, subtract, scale, divide,
// tolerance compare, normalize and length. A new item is taken every cycle
// unless a waiting result stalls a full last divider stage. Each item passes
// the 16-stage square root and the divider that resolves two quotient bits
// per stage. Every opcode runs the same path, so results leave in order. A
// stalled result holds the output register while the pipeline keeps filling
// its empty stages.
// Depends on vfa_pkg, the three channel interfaces, vfa_sqrt and vfa_div.
`default_nettype none

module vec3_fixed_alu import vfa_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  vfa_cfg_if.sink   cfg_i,
  vfa_req_if.sink   req_i,
  vfa_res_if.source res_o
);

  localparam int unsigned NUM_W = DATA_W + FRAC_BITS;

  // Tolerance register
  logic [TOL_W-1:0] tol_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_i.valid) begin
      tol_q <= cfg_i.equal_tolerance;
    end
  end

  // Global advance: stall only when the output waits and the last stage is full
  logic en;
  logic out_free;
  logic div_vld;
  logic out_vld_q;

  assign out_free    = !out_vld_q || res_o.ready;
  assign en          = out_free || !div_vld;
  assign req_i.ready = en;

  // Stage 1: capture the item
  logic                   p1_vld_q;
  op_e                    p1_op_q;
  logic [2:0][DATA_W-1:0] p1_a_q, p1_b_q;
  logic [DATA_W-1:0]      p1_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_op_q   <= op_e'(req_i.req_type);
      p1_a_q[0] <= req_i.a_x;
      p1_a_q[1] <= req_i.a_y;
      p1_a_q[2] <= req_i.a_z;
      p1_b_q[0] <= req_i.b_x;
      p1_b_q[1] <= req_i.b_y;
      p1_b_q[2] <= req_i.b_z;
      p1_s_q    <= req_i.scalar;
    end
  end

  // Stage 2: magnitudes, products, squares, sums
  logic                   p2_vld_q;
  op_e                    p2_op_q;
  logic [2:0][DATA_W-1:0] p2_ma_q, p2_ma_d;
  logic [2:0]             p2_na_q;
  logic [DATA_W-1:0]      p2_ms_q, p2_ms_d;
  logic                   p2_ns_q;
  logic                   p2_szero_q;
  logic [2:0][63:0]       p2_prod_q, p2_prod_d;
  logic [2:0][63:0]       p2_sq_q, p2_sq_d;
  logic [2:0][DATA_W:0]   p2_sum_q, p2_sum_d;
  logic [2:0][DATA_W:0]   p2_diff_q, p2_diff_d;

  always_comb begin
    p2_ms_d = p1_s_q[DATA_W-1] ? DATA_W'(-p1_s_q) : p1_s_q;
    for (int i = 0; i < 3; i++) begin
      p2_ma_d[i]   = p1_a_q[i][DATA_W-1] ? DATA_W'(-p1_a_q[i]) : p1_a_q[i];
      p2_prod_d[i] = $signed(p1_a_q[i]) * $signed(p1_s_q);
      // Square the signed component directly, it is never negative
      p2_sq_d[i]   = $signed(p1_a_q[i]) * $signed(p1_a_q[i]);
      p2_diff_d[i] = {p1_a_q[i][DATA_W-1], p1_a_q[i]} - {p1_b_q[i][DATA_W-1], p1_b_q[i]};
      if (p1_op_q == OP_SUB) begin
        p2_sum_d[i] = p2_diff_d[i];
      end else begin
        p2_sum_d[i] = {p1_a_q[i][DATA_W-1], p1_a_q[i]} + {p1_b_q[i][DATA_W-1], p1_b_q[i]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else if (en) begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_op_q    <= p1_op_q;
      p2_ma_q    <= p2_ma_d;
      p2_na_q    <= {p1_a_q[2][DATA_W-1], p1_a_q[1][DATA_W-1], p1_a_q[0][DATA_W-1]};
      p2_ms_q    <= p2_ms_d;
      p2_ns_q    <= p1_s_q[DATA_W-1];
      p2_szero_q <= (p1_s_q == '0);
      p2_prod_q  <= p2_prod_d;
      p2_sq_q    <= p2_sq_d;
      p2_sum_q   <= p2_sum_d;
      p2_diff_q  <= p2_diff_d;
    end
  end

  // Stage 3: radicand, and results of the simple operations
  logic       p3_vld_q;
  logic [63:0] p3_rad_q;
  sb_sqrt_t   p3_sb_q, p3_sb_d;

  always_comb begin
    logic [63:0]     mp, sm;
    logic [DATA_W:0] ms, md;
    pack_t           pk;
    logic            hit;
    p3_sb_d       = '0;
    p3_sb_d.op    = p2_op_q;
    p3_sb_d.ma    = p2_ma_q;
    p3_sb_d.na    = p2_na_q;
    p3_sb_d.ms    = p2_ms_q;
    p3_sb_d.ns    = p2_ns_q;
    p3_sb_d.szero = p2_szero_q;
    hit           = 1'b1;
    for (int i = 0; i < 3; i++) begin
      md = p2_diff_q[i][DATA_W] ? (DATA_W+1)'(-p2_diff_q[i]) : p2_diff_q[i];
      if (md >= {2'b00, tol_q}) begin
        hit = 1'b0;
      end
      case (p2_op_q)
        OP_ADD, OP_SUB: begin
          ms = p2_sum_q[i][DATA_W] ? (DATA_W+1)'(-p2_sum_q[i]) : p2_sum_q[i];
          pk = sat_pack(p2_sum_q[i][DATA_W], 64'(ms));
          p3_sb_d.r[i] = pk.val;
          p3_sb_d.sat  = p3_sb_d.sat | pk.sat;
        end
        OP_SCALE: begin
          mp = p2_prod_q[i][63] ? 64'(-p2_prod_q[i]) : p2_prod_q[i];
          sm = (mp + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
          pk = sat_pack(p2_prod_q[i][63], sm);
          p3_sb_d.r[i] = pk.val;
          p3_sb_d.sat  = p3_sb_d.sat | pk.sat;
        end
        default: begin
        end
      endcase
    end
    p3_sb_d.match = (p2_op_q == OP_EQ) && hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_vld_q <= 1'b0;
    end else if (en) begin
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_rad_q <= p2_sq_q[0] + p2_sq_q[1] + p2_sq_q[2];
      p3_sb_q  <= p3_sb_d;
    end
  end

  // Square root of the sum of squares
  localparam int unsigned SB_SQRT_W = $bits(sb_sqrt_t);
  localparam int unsigned SB_DIV_W  = $bits(sb_div_t);

  logic                  sq_vld;
  logic [DATA_W-1:0]     sq_root;
  logic [DATA_W:0]       sq_rem;
  logic [SB_SQRT_W-1:0]  sq_sb;

  vfa_sqrt #(
    .SB_W (SB_SQRT_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p3_vld_q),
    .rad_i   (p3_rad_q),
    .sb_i    (p3_sb_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .rem_o   (sq_rem),
    .sb_o    (sq_sb)
  );

  // Stage 4: round the length, pick the divisor, flag faults
  logic                  p4_vld_q;
  logic [2:0][NUM_W-1:0] p4_num_q, p4_num_d;
  logic [DEN_W-1:0]      p4_den_q, p4_den_d;
  sb_div_t               p4_sb_q, p4_sb_d;

  always_comb begin
    sb_sqrt_t         s1;
    logic [DEN_W-1:0] len;
    pack_t            pk;
    s1            = sb_sqrt_t'(sq_sb);
    len           = {1'b0, sq_root} + DEN_W'(sq_rem > {1'b0, sq_root});
    pk            = sat_pack(1'b0, 64'(len));
    p4_sb_d       = '0;
    p4_sb_d.op    = s1.op;
    p4_sb_d.r     = s1.r;
    p4_sb_d.match = s1.match;
    p4_sb_d.sat   = s1.sat;
    p4_sb_d.fault = ((s1.op == OP_DIV) && s1.szero) || ((s1.op == OP_NORM) && len == '0);
    p4_den_d      = (s1.op == OP_DIV) ? {1'b0, s1.ms} : len;
    if (s1.op == OP_LEN) begin
      p4_sb_d.r[0] = pk.val;
      p4_sb_d.sat  = pk.sat;
    end
    for (int i = 0; i < 3; i++) begin
      p4_sb_d.neg[i] = (s1.op == OP_DIV) ? (s1.na[i] ^ s1.ns) : s1.na[i];
      p4_num_d[i]    = {s1.ma[i], {FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_vld_q <= 1'b0;
    end else if (en) begin
      p4_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_num_q <= p4_num_d;
      p4_den_q <= p4_den_d;
      p4_sb_q  <= p4_sb_d;
    end
  end

  // Divide the three shifted magnitudes
  logic [2:0][NUM_W-1:0] dv_quo;
  logic [2:0][DEN_W-1:0] dv_rem;
  logic [DEN_W-1:0]      dv_den;
  logic [SB_DIV_W-1:0]   dv_sb;

  vfa_div #(
    .NUM_W (NUM_W),
    .SB_W  (SB_DIV_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p4_vld_q),
    .num_i   (p4_num_q),
    .den_i   (p4_den_q),
    .sb_i    (p4_sb_q),
    .valid_o (div_vld),
    .quo_o   (dv_quo),
    .rem_o   (dv_rem),
    .den_o   (dv_den),
    .sb_o    (dv_sb)
  );

  // Stage 5: round quotients, saturate, select the result
  logic [2:0][DATA_W-1:0] out_r_q, out_r_d;
  logic                   out_match_q, out_match_d;
  logic                   out_fault_q, out_fault_d;
  logic                   out_sat_q, out_sat_d;

  always_comb begin
    sb_div_t          s2;
    logic [NUM_W:0]   qr;
    logic             up;
    pack_t            pk;
    logic [2:0][DATA_W-1:0] dr;
    logic             dsat;
    s2   = sb_div_t'(dv_sb);
    dsat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      up    = {dv_rem[i], 1'b0} >= {1'b0, dv_den};
      qr    = {1'b0, dv_quo[i]} + (NUM_W+1)'(up);
      pk    = sat_pack(s2.neg[i], 64'(qr));
      dr[i] = pk.val;
      dsat  = dsat | pk.sat;
    end
    out_r_d     = s2.r;
    out_match_d = s2.match;
    out_fault_d = s2.fault;
    out_sat_d   = s2.sat;
    case (s2.op)
      OP_DIV, OP_NORM: begin
        if (s2.fault) begin
          out_r_d   = '0;
          out_sat_d = 1'b0;
        end else begin
          out_r_d   = dr;
          out_sat_d = dsat;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: load when free, hold while the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_r_q     <= out_r_d;
      out_match_q <= out_match_d;
      out_fault_q <= out_fault_d;
      out_sat_q   <= out_sat_d;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.res_x      = out_r_q[0];
  assign res_o.res_y      = out_r_q[1];
  assign res_o.res_z      = out_r_q[2];
  assign res_o.match_flag = out_match_q;
  assign res_o.fault      = out_fault_q;
  assign res_o.saturated  = out_sat_q;

  // A fault result is all zero and carries no other flag
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_fault_q) |-> (out_r_q == '0 && !out_sat_q && !out_match_q))
    else $error("fault result not cleared");

  // A match result is all zero and never clamped
  a_match_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_match_q) |-> (out_r_q == '0 && !out_sat_q && !out_fault_q))
    else $error("match result not cleared");

  // A waiting result holds until the sink takes it
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_o.ready) |=> (out_vld_q && $stable(out_r_q)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- verif/vec3_fixed_alu_tb.sv -----
// Self-checking testbench for vec3_fixed_alu: directed and random vector items, predicted
// in-bench and compared in order. Depends on vfa_pkg, the channel interfaces and the ALU.
`timescale 1ns / 100ps

module vec3_fixed_alu_tb;
  import vfa_pkg::*;

  localparam int unsigned FB = FRAC_BITS_DEF;
  localparam int unsigned LAT = 45;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] ax, ay, az, bx, by, bz, s;
  } vreq_t;

  typedef struct packed {
    logic [31:0] x, y, z;
    logic        match, fault, sat;
  } vres_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  vfa_cfg_if cfg_if ();
  vfa_req_if req_if ();
  vfa_res_if res_if ();

  vec3_fixed_alu u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if.sink),
    .req_i (req_if.sink),
    .res_o (res_if.source)
  );

  vres_t       expected_q[$];
  logic [30:0] tol_model;
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_cycles = 0;

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #50ms;
    $display("** vec3_fixed_alu: FAILED **");
    $finish;
  end

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] rnd_div(input logic [63:0] n, input logic [63:0] d);
    return (2 * n + d) / (2 * d);
  endfunction

  function automatic logic [63:0] root_round(input logic [63:0] v);
    logic [63:0] r, b, x;
    r = 0; b = 64'd1 << 62; x = v;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (v - r * r > r) r = r + 1;
    return r;
  endfunction

  function automatic logic [31:0] clamp(input logic neg, input logic [63:0] m,
                                        inout logic sat);
    if (neg) begin
      if (m > 64'h8000_0000) begin sat = 1'b1; m = 64'h8000_0000; end
      return 32'(64'd0 - m);
    end
    if (m > 64'h7FFF_FFFF) begin sat = 1'b1; m = 64'h7FFF_FFFF; end
    return m[31:0];
  endfunction

  // Predict the result of one item
  function automatic vres_t alu_predict(input vreq_t q);
    logic signed [63:0] a[3], b[3], s, v, p;
    logic [31:0] r[3];
    logic [63:0] sq, len, m;
    vres_t o;
    a[0] = 64'(signed'(q.ax)); a[1] = 64'(signed'(q.ay)); a[2] = 64'(signed'(q.az));
    b[0] = 64'(signed'(q.bx)); b[1] = 64'(signed'(q.by)); b[2] = 64'(signed'(q.bz));
    s = 64'(signed'(q.s));
    r[0] = 0; r[1] = 0; r[2] = 0;
    o = '0;
    case (q.op)
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          v = (q.op == OP_ADD) ? a[i] + b[i] : a[i] - b[i];
          r[i] = clamp(v < 0, mag(v), o.sat);
        end
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          p = a[i] * s;
          m = (mag(p) + (64'd1 << (FB - 1))) >> FB;
          r[i] = clamp(p < 0, m, o.sat);
        end
      end
      OP_DIV: begin
        if (s == 0) o.fault = 1'b1;
        else
          for (int i = 0; i < 3; i++)
            r[i] = clamp((a[i] < 0) != (s < 0), rnd_div(mag(a[i]) << FB, mag(s)), o.sat);
      end
      OP_EQ: begin
        o.match = 1'b1;
        for (int i = 0; i < 3; i++)
          if (mag(a[i] - b[i]) >= 64'(tol_model)) o.match = 1'b0;
      end
      OP_NORM, OP_LEN: begin
        sq = 0;
        for (int i = 0; i < 3; i++) sq = sq + mag(a[i]) * mag(a[i]);
        len = root_round(sq);
        if (q.op == OP_LEN) r[0] = clamp(1'b0, len, o.sat);
        else if (len == 0) o.fault = 1'b1;
        else
          for (int i = 0; i < 3; i++)
            r[i] = clamp(a[i] < 0, rnd_div(mag(a[i]) << FB, len), o.sat);
      end
      default: ;
    endcase
    o.x = r[0]; o.y = r[1]; o.z = r[2];
    return o;
  endfunction

  // Send one item, idling before it at the current rate; valid stays up after it
  task automatic send_item(input vreq_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= q.op;
    req_if.a_x <= q.ax; req_if.a_y <= q.ay; req_if.a_z <= q.az;
    req_if.b_x <= q.bx; req_if.b_y <= q.by; req_if.b_z <= q.bz;
    req_if.scalar <= q.s;
    do @(posedge clk_i); while (!req_if.ready);
    expected_q.push_back(alu_predict(q));
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected result has come
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (LAT + 5) @(negedge clk_i);
  endtask

  task automatic write_tolerance(input logic [30:0] t);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.equal_tolerance <= t;
    do @(posedge clk_i); while (!cfg_if.ready);
    tol_model = t;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000 | $urandom_range(3);
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return 32'(signed'($urandom_range(0, 200000)) - 100000);
      3: return 32'(signed'($urandom_range(0, 1 << 22)) - (1 << 21));
      default: return $urandom;
    endcase
  endfunction

  function automatic vreq_t rand_item();
    vreq_t q;
    q.op = 3'($urandom_range(7));
    q.ax = rand_word(); q.ay = rand_word(); q.az = rand_word();
    q.s  = $urandom_range(9) == 0 ? 32'd0 : rand_word();
    if (q.op == OP_EQ && $urandom_range(1)) begin
      // Near-equal vectors to exercise both sides of the tolerance
      q.bx = q.ax + $urandom_range(0, 16) - 8;
      q.by = q.ay + $urandom_range(0, 16) - 8;
      q.bz = q.az + $urandom_range(0, 16) - 8;
    end else begin
      q.bx = rand_word(); q.by = rand_word(); q.bz = rand_word();
    end
    if (q.op == OP_NORM && $urandom_range(15) == 0) begin
      q.ax = 0; q.ay = 0; q.az = 0;
    end
    return q;
  endfunction

  function automatic vreq_t mk(input logic [2:0] op, input logic [31:0] a, b, s);
    vreq_t q;
    q.op = op; q.ax = a; q.ay = -a; q.az = a >>> 1;
    q.bx = b; q.by = b; q.bz = -b; q.s = s;
    return q;
  endfunction

  // Directed: extremes, every opcode, zero divisor, zero vector, unused opcode
  task automatic test_directed();
    send_item(mk(OP_ADD,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    send_item(mk(OP_ADD,   32'h8000_0000, 32'h8000_0000, 0));
    send_item(mk(OP_SUB,   32'h8000_0000, 32'h0001_0000, 0));
    send_item(mk(OP_SUB,   32'h7FFF_FFFF, 32'h8000_0000, 0));
    send_item(mk(OP_SCALE, 32'h0003_0000, 0, 32'hFFFE_8000));
    send_item(mk(OP_SCALE, 32'h8000_0000, 0, 32'h8000_0000));
    send_item(mk(OP_SCALE, 32'h0000_0001, 0, 32'h0000_8000));
    send_item(mk(OP_DIV,   32'h0001_0000, 0, 32'h0003_0000));
    send_item(mk(OP_DIV,   32'h7FFF_FFFF, 0, 32'h0000_0001));
    send_item(mk(OP_DIV,   32'h8000_0000, 0, 32'hFFFF_FFFF));
    send_item(mk(OP_DIV,   32'h0005_0000, 0, 32'h0));
    send_item(mk(OP_EQ,    32'h0001_0000, 32'h0001_0000, 0));
    send_item(mk(OP_EQ,    32'h0001_0006, 32'h0001_0000, 0));
    send_item(mk(OP_EQ,    32'h8000_0000, 32'h7FFF_FFFF, 0));
    send_item(mk(OP_NORM,  32'h0002_0000, 0, 0));
    send_item(mk(OP_NORM,  32'h8000_0000, 0, 0));
    send_item(mk(OP_NORM,  32'h0000_0001, 0, 0));
    send_item(mk(OP_NORM,  32'h0, 0, 0));
    send_item(mk(OP_LEN,   32'h8000_0000, 0, 0));
    send_item(mk(OP_LEN,   32'h0003_0000, 0, 0));
    send_item(mk(OP_LEN,   32'h0, 0, 0));
    send_item(mk(3'd7,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_random(input int n, input int sp, input int rp);
    send_idle_pct = sp;
    recv_idle_pct = rp;
    repeat (n) send_item(rand_item());
  endtask

  // Hold off the receiver while items keep coming, then pause until drained
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 200;
    repeat (120) send_item(rand_item());
    wait_drained();
  endtask

  // Result checker and receiver ready
  always @(posedge clk_i) begin
    vres_t got, exp_r;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = {res_if.res_x, res_if.res_y, res_if.res_z,
             res_if.match_flag, res_if.fault, res_if.saturated};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.x !== exp_r.x) begin
          $display("%0t: res_x exp %h got %h", $time, exp_r.x, got.x); errors++;
        end
        if (got.y !== exp_r.y) begin
          $display("%0t: res_y exp %h got %h", $time, exp_r.y, got.y); errors++;
        end
        if (got.z !== exp_r.z) begin
          $display("%0t: res_z exp %h got %h", $time, exp_r.z, got.z); errors++;
        end
        if (got.match !== exp_r.match) begin
          $display("%0t: match exp %b got %b", $time, exp_r.match, got.match); errors++;
        end
        if (got.fault !== exp_r.fault) begin
          $display("%0t: fault exp %b got %b", $time, exp_r.fault, got.fault); errors++;
        end
        if (got.sat !== exp_r.sat) begin
          $display("%0t: saturated exp %b got %b", $time, exp_r.sat, got.sat); errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.req_type = '0;
    req_if.a_x = 0; req_if.a_y = 0; req_if.a_z = 0;
    req_if.b_x = 0; req_if.b_y = 0; req_if.b_z = 0;
    req_if.scalar = 0;
    cfg_if.valid = 1'b0;
    cfg_if.equal_tolerance = '0;
    res_if.ready = 1'b0;
    tol_model = TOL_RESET;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    write_tolerance(31'd0);
    test_directed();
    write_tolerance(31'h7FFF_FFFF);
    test_random(480, 26, 66);
    write_tolerance(31'd4);
    test_random(480, 66, 26);
    write_tolerance(TOL_RESET);
    test_backpressure();
    test_random(350, 0, 0);
    wait_drained();

    if (errors == 0) $display("** vec3_fixed_alu: PASSED **");
    else $display("** vec3_fixed_alu: FAILED **");
    $finish;
  end
endmodule
